FILE: rtl/core/ros_pkg.sv
package ros_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_ITEMS_DEF  = 64;
   localparam int VALUE_BITS_DEF = 24;

   // Fixed field widths
   localparam int H_IN_W    = 24;
   localparam int COST_IN_W = 25;
   localparam int IDX_OUT_W = 6;

   // CSR map
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALLOW_NEG_COST = 2'd0,
      CSR_ASCENDING      = 2'd1
   } csr_idx_type;

endpackage

FILE: rtl/core/ratio_ordered_sorter_unit.sv
// Load: one entry transaction per cycle, busy stays low while entries are loaded.
// Emission on the entry marked last: n selection passes over the entry RAM, each
// pass one RAM read in FETCH, then a multiply (MUL) and a compare (CMP) per entry;
// the pick of each pass is emitted as a result when the pass completes.
// Results are strobed for one cycle; the receiver cannot stall them.
// Reset clears config, entry count, error flag and taken mask; the RAM is not cleared.
module ratio_ordered_sorter_unit #(
   parameter int MAX_ITEMS  = ros_pkg::MAX_ITEMS_DEF,
   parameter int VALUE_BITS = ros_pkg::VALUE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // entry transactions
   input  logic                                 start,
   output logic                                 busy,
   input  logic [ros_pkg::H_IN_W-1:0]           req_h_value,
   input  logic signed [ros_pkg::COST_IN_W-1:0] req_used_cost,
   input  logic                                 req_last,
   // result transactions
   output logic                                 rsp_valid,
   output logic [ros_pkg::IDX_OUT_W-1:0]        rsp_entry_index,
   output logic                                 rsp_error,
   output logic                                 rsp_last_res,
   // CSR writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ros_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ros_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import ros_pkg::*;

   localparam int IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int VB     = VALUE_BITS;
   localparam int PROD_W = 2 * VB + 1;
   localparam logic [31:0] VMAX32 = (32'd1 << VALUE_BITS) - 32'd1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FETCH = 4'b0010,
      ST_MUL   = 4'b0100,
      ST_CMP   = 4'b1000
   } state_type;

   // Entry RAM: {h, cost}, one write port, one registered read port
   logic [2*VB-1:0] entry_mem [MAX_ITEMS];
   logic [2*VB-1:0] rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             rd_en;
   logic             wr_en;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              err_ff, err_in;
   logic [MAX_ITEMS-1:0] taken_ff, taken_in;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [VB-1:0]     best_h_ff, best_h_in;
   logic [VB-1:0]     best_c_ff, best_c_in;
   logic [VB-1:0]     cand_h_ff;
   logic [VB-1:0]     cand_c_ff;
   logic [PROD_W-1:0] prod_cand_ff;   // h_cand * (cost_best + 1)
   logic [PROD_W-1:0] prod_best_ff;   // h_best * (cost_cand + 1)
   logic              allow_neg_ff;
   logic              ascend_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_idx_ff;
   logic              rsp_err_ff;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              room;
   logic [31:0]       h_ext;
   logic [31:0]       c_ext;
   logic [VB-1:0]     h_sat;
   logic [VB-1:0]     c_sat;
   logic              cost_neg;
   logic [VB-1:0]     rd_h;
   logic [VB-1:0]     rd_c;
   logic [VB:0]       best_c_p1;
   logic [VB:0]       rd_c_p1;
   logic              replace;
   logic              scan_done;
   logic              pos_done;
   logic [IDX_W-1:0]  pick_idx;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign room      = (count_ff != CNT_W'(MAX_ITEMS));

   // Input conditioning: saturate to VALUE_BITS, negative cost becomes zero
   assign cost_neg = req_used_cost[COST_IN_W-1];
   assign h_ext    = 32'(req_h_value);
   assign c_ext    = 32'(req_used_cost[COST_IN_W-2:0]);
   assign h_sat    = (h_ext > VMAX32) ? VMAX32[VB-1:0] : h_ext[VB-1:0];
   assign c_sat    = cost_neg ? '0
                   : ((c_ext > VMAX32) ? VMAX32[VB-1:0] : c_ext[VB-1:0]);

   assign wr_en = accept && room;

   // Read port: first entry of a pass in FETCH, the following entry in MUL
   assign rd_en   = (state_ff == ST_FETCH) || (state_ff == ST_MUL);
   assign rd_addr = (state_ff == ST_MUL) ? scan_ff + IDX_W'(1) : scan_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[count_ff[IDX_W-1:0]] <= {h_sat, c_sat};
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_h      = rd_data_ff[2*VB-1:VB];
   assign rd_c      = rd_data_ff[VB-1:0];
   assign best_c_p1 = (VB+1)'(best_c_ff) + (VB+1)'(1);
   assign rd_c_p1   = (VB+1)'(rd_c) + (VB+1)'(1);

   // Descending: candidate wins only on a strictly higher ratio (lower index
   // keeps ties). Ascending picks the last of the descending order, so equal
   // ratios go to the later, higher index.
   always_comb begin
      if (taken_ff[scan_ff]) begin
         replace = 1'b0;
      end else if (!found_ff) begin
         replace = 1'b1;
      end else if (ascend_ff) begin
         replace = (prod_cand_ff <= prod_best_ff);
      end else begin
         replace = (prod_cand_ff > prod_best_ff);
      end
   end

   assign scan_done = (CNT_W'(scan_ff) + CNT_W'(1) == count_ff);
   assign pos_done  = (pos_ff + CNT_W'(1) == count_ff);
   assign pick_idx  = replace ? scan_ff : best_idx_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      taken_in     = taken_ff;
      scan_in      = scan_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_h_in    = best_h_ff;
      best_c_in    = best_c_ff;
      rsp_valid_in = 1'b0;
      rsp_last_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (wr_en) begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (!room || (cost_neg && !allow_neg_ff)) begin
                  err_in = 1'b1;
               end
               if (req_last) begin
                  scan_in  = '0;
                  pos_in   = '0;
                  taken_in = '0;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            found_in = 1'b0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (replace) begin
               found_in    = 1'b1;
               best_idx_in = scan_ff;
               best_h_in   = cand_h_ff;
               best_c_in   = cand_c_ff;
            end
            if (scan_done) begin
               // pass complete: emit the pick and mark it taken
               rsp_valid_in       = 1'b1;
               rsp_last_in        = pos_done;
               taken_in[pick_idx] = 1'b1;
               pos_in             = pos_ff + CNT_W'(1);
               scan_in            = '0;
               if (pos_done) begin
                  count_in = '0;
                  err_in   = 1'b0;
                  taken_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_FETCH;
               end
            end else begin
               scan_in  = scan_ff + IDX_W'(1);
               state_in = ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         err_ff       <= 1'b0;
         taken_ff     <= '0;
         scan_ff      <= '0;
         pos_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         allow_neg_ff <= 1'b0;
         ascend_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         taken_ff     <= taken_in;
         scan_ff      <= scan_in;
         pos_ff       <= pos_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ALLOW_NEG_COST: allow_neg_ff <= csr_wdata[0];
               CSR_ASCENDING:      ascend_ff    <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // Datapath registers, no reset needed
   always_ff @(posedge clock) begin
      best_idx_ff <= best_idx_in;
      best_h_ff   <= best_h_in;
      best_c_ff   <= best_c_in;
      if (state_ff == ST_MUL) begin
         cand_h_ff    <= rd_h;
         cand_c_ff    <= rd_c;
         prod_cand_ff <= PROD_W'(rd_h) * PROD_W'(best_c_p1);
         prod_best_ff <= PROD_W'(best_h_ff) * PROD_W'(rd_c_p1);
      end
      if (rsp_valid_in) begin
         rsp_idx_ff  <= pick_idx;
         rsp_err_ff  <= err_ff;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_index = IDX_OUT_W'(rsp_idx_ff);
   assign rsp_error       = rsp_err_ff;
   assign rsp_last_res    = rsp_last_ff;

endmodule
